@@ sv/rcc_pkg.sv @@
package rcc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int WORD_W      = 64;
  localparam int IN_W        = 6 * COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [WORD_W-1:0] fx_t;
  typedef logic [WORD_W-2:0] fx_mag_t;

  localparam fx_t FX_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W:0] SUM_MAX = {2'b00, {(WORD_W-1){1'b1}}};

  localparam int MUL_LAT    = 4;
  localparam int SQRT_STEPS = (WORD_W + FRAC_BITS) / 2;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_STEPS  = WORD_W - 1 + FRAC_BITS;
  localparam int DIV_LAT    = DIV_STEPS + 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd6;

  // saturating add, clamped to the symmetric range
  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [WORD_W:0] s;
    fx_t r;
    s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
    if (s > SUM_MAX) r = FX_MAX;
    else if (s < -SUM_MAX) r = -FX_MAX;
    else r = s[WORD_W-1:0];
    return r;
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    return fx_add(a, -b);
  endfunction

  function automatic fx_mag_t fx_abs(fx_t a);
    fx_t n;
    n = a[WORD_W-1] ? -a : a;
    return n[WORD_W-2:0];
  endfunction

endpackage

@@ sv/rcc_fmul.sv @@
module rcc_fmul (
  input  logic          clk,
  input  logic          en,
  input  rcc_pkg::fx_t  a,
  input  rcc_pkg::fx_t  b,
  output rcc_pkg::fx_t  p
);
  import rcc_pkg::*;

  localparam int HALF = WORD_W / 2;
  localparam int PW   = 2 * WORD_W;

  fx_mag_t ma_r, mb_r;
  logic neg1_r, neg2_r, neg3_r;
  logic [WORD_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [PW-1:0] sum_r;
  logic [PW-1:0] sum_nxt;
  logic [HALF-1:0] al, ah, bl, bh;
  fx_t v;
  fx_t p_r;

  assign al = ma_r[HALF-1:0];
  assign ah = {1'b0, ma_r[WORD_W-2:HALF]};
  assign bl = mb_r[HALF-1:0];
  assign bh = {1'b0, mb_r[WORD_W-2:HALF]};

  assign sum_nxt = {{WORD_W{1'b0}}, pll_r}
                 + {{HALF{1'b0}}, plh_r, {HALF{1'b0}}}
                 + {{HALF{1'b0}}, phl_r, {HALF{1'b0}}}
                 + {phh_r, {WORD_W{1'b0}}};

  always_comb begin
    if (|sum_r[PW-1:WORD_W-1+FRAC_BITS]) v = FX_MAX;
    else v = {1'b0, sum_r[WORD_W-2+FRAC_BITS:FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= fx_abs(a);
      mb_r   <= fx_abs(b);
      neg1_r <= a[WORD_W-1] ^ b[WORD_W-1];
      pll_r  <= al * bl;
      plh_r  <= al * bh;
      phl_r  <= ah * bl;
      phh_r  <= ah * bh;
      neg2_r <= neg1_r;
      sum_r  <= sum_nxt;
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? -v : v;
    end
  end

  assign p = p_r;

endmodule

@@ sv/rcc_sqrt.sv @@
module rcc_sqrt (
  input  logic          clk,
  input  logic          en,
  input  rcc_pkg::fx_t  x,
  output rcc_pkg::fx_t  root
);
  import rcc_pkg::*;

  localparam int RAD_W  = 2 * SQRT_STEPS;
  localparam int REM_W  = SQRT_STEPS + 3;
  localparam int ROOT_W = SQRT_STEPS;

  logic [RAD_W-1:0]  rad_r  [0:SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [0:SQRT_STEPS];
  logic [RAD_W-1:0]  rad_nxt  [0:SQRT_STEPS-1];
  logic [REM_W-1:0]  rem_nxt  [0:SQRT_STEPS-1];
  logic [ROOT_W-1:0] root_nxt [0:SQRT_STEPS-1];
  logic [REM_W-1:0]  part [0:SQRT_STEPS-1];
  logic [REM_W-1:0]  trial [0:SQRT_STEPS-1];

  // one result bit per stage, two radicand bits shifted in
  always_comb begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      part[i]    = {rem_r[i][REM_W-3:0], rad_r[i][RAD_W-1 -: 2]};
      trial[i]   = {1'b0, root_r[i], 2'b01};
      rad_nxt[i] = rad_r[i] << 2;
      if (part[i] >= trial[i]) begin
        rem_nxt[i]  = part[i] - trial[i];
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = part[i];
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= {{(RAD_W-WORD_W+1){1'b0}}, x[WORD_W-2:0]} << FRAC_BITS;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int i = 0; i < SQRT_STEPS; i++) begin
        rad_r[i+1]  <= rad_nxt[i];
        rem_r[i+1]  <= rem_nxt[i];
        root_r[i+1] <= root_nxt[i];
      end
    end
  end

  assign root = {{(WORD_W-ROOT_W){1'b0}}, root_r[SQRT_STEPS]};

endmodule

@@ sv/rcc_div.sv @@
module rcc_div (
  input  logic          clk,
  input  logic          en,
  input  rcc_pkg::fx_t  num,
  input  rcc_pkg::fx_t  den,
  output rcc_pkg::fx_t  quo
);
  import rcc_pkg::*;

  // dividend bits shift out the top while quotient bits shift in below
  logic [DIV_STEPS-1:0] nq_r [0:DIV_STEPS];
  fx_mag_t              rm_r [0:DIV_STEPS];
  fx_mag_t              d_r  [0:DIV_STEPS];
  logic                 neg_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] nq_nxt [0:DIV_STEPS-1];
  fx_mag_t              rm_nxt [0:DIV_STEPS-1];
  logic [WORD_W-1:0]    shifted [0:DIV_STEPS-1];
  logic [WORD_W-1:0]    diff [0:DIV_STEPS-1];
  logic                 ge [0:DIV_STEPS-1];
  logic [DIV_STEPS-1:0] q;
  fx_t v;
  fx_t quo_r;

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      shifted[i] = {rm_r[i], nq_r[i][DIV_STEPS-1]};
      ge[i]      = shifted[i] >= {1'b0, d_r[i]};
      diff[i]    = shifted[i] - {1'b0, d_r[i]};
      rm_nxt[i]  = ge[i] ? diff[i][WORD_W-2:0] : shifted[i][WORD_W-2:0];
      nq_nxt[i]  = {nq_r[i][DIV_STEPS-2:0], ge[i]};
    end
  end

  assign q = nq_r[DIV_STEPS];

  always_comb begin
    if (|q[DIV_STEPS-1:WORD_W-1]) v = FX_MAX;
    else v = {1'b0, q[WORD_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= {{(DIV_STEPS-WORD_W+1){1'b0}}, fx_abs(num)} << FRAC_BITS;
      rm_r[0]  <= '0;
      d_r[0]   <= fx_abs(den);
      neg_r[0] <= num[WORD_W-1] ^ den[WORD_W-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        nq_r[i+1]  <= nq_nxt[i];
        rm_r[i+1]  <= rm_nxt[i];
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
      quo_r <= neg_r[DIV_STEPS] ? -v : v;
    end
  end

  assign quo = quo_r;

endmodule

@@ sv/ray_capped_cylinder_intersect.sv @@
// Ray against capped cylinder, fully pipelined, one ray per clock.
// Pipeline depth is set by two 81-stage restoring dividers, a 41-stage square
// root and 4-stage multipliers.
// Throughput: one ray per cycle; the whole pipe holds while a result waits.
// Reset (rst_n low, synchronous) empties the pipe and loads the default
// cylinder: base (0,0,0), top (0,1.0,0), radius 1.0.
module ray_capped_cylinder_intersect (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rcc_pkg::IN_W-1:0]        in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // distance
  output logic [rcc_pkg::COORD_WIDTH-1:0] out_tdata,
  // hit
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcc_pkg::COORD_WIDTH-1:0] cfg_data
);
  import rcc_pkg::*;

  localparam int CW = COORD_WIDTH;

  localparam int T_M1  = MUL_LAT;
  localparam int T_A1  = T_M1 + 1;
  localparam int T_DOT = T_A1 + 1;
  localparam int T_M2  = T_DOT + MUL_LAT;
  localparam int T_Q1  = T_M2 + 1;
  localparam int T_Q2  = T_Q1 + 1;
  localparam int T_M3  = T_Q2 + MUL_LAT;
  localparam int T_H   = T_M3 + 1;
  localparam int T_SQ  = T_H + SQRT_LAT;
  localparam int T_N1  = T_SQ + 1;
  localparam int T_D1  = T_N1 + DIV_LAT;
  localparam int T_M4  = T_D1 + MUL_LAT;
  localparam int T_Y   = T_M4 + 1;
  localparam int T_N2  = T_Y + 1;
  localparam int T_D2  = T_N2 + DIV_LAT;
  localparam int T_M5  = T_D2 + MUL_LAT;
  localparam int T_S   = T_M5 + 1;
  localparam int T_OUT = T_S + 1;

  // delay line lengths: entry k holds the value of stage A+1+k
  localparam int DOT_LEN  = T_Y - T_DOT;
  localparam int RR_LEN   = T_DOT - T_M1;
  localparam int QA_LEN   = T_D2 - T_Q1;
  localparam int QB_LEN   = T_M5 - T_Q1;
  localparam int OK_LEN   = T_S - T_H;
  localparam int HS_LEN   = T_S - T_SQ;
  localparam int T1_LEN   = T_S - T_D1;
  localparam int SIDE_LEN = T_S - T_N2;
  localparam int T2_LEN   = T_S - T_D2;

  localparam int DOT_CC = 0;
  localparam int DOT_CR = 1;
  localparam int DOT_CO = 2;
  localparam int DOT_OD = 3;
  localparam int DOT_OO = 4;

  localparam fx_t FX_ONE_LSB = 64'sd1;

  function automatic fx_t sx(logic [CW-1:0] v);
    return {{(WORD_W-CW){v[CW-1]}}, v};
  endfunction

  logic en;
  logic [T_OUT:0] vld_r;

  logic [CW-1:0] base_r [0:2];
  logic [CW-1:0] top_r  [0:2];
  logic [CW-2:0] radius_r;

  fx_t ca_r [0:2];
  fx_t oc_r [0:2];
  fx_t dir_r [0:2];
  fx_t rad0_r;

  fx_t m1_a [0:15];
  fx_t m1_b [0:15];
  fx_t m1_p [0:15];
  fx_t a1_r [0:4];
  fx_t a1z_r [0:4];
  fx_t dot_r [0:4];
  fx_t rr_d_r [0:RR_LEN-1];

  fx_t crcr, ccod, cocr, ccoo, coco, rrcc;
  fx_t cc_d_r [0:DOT_LEN-1];
  fx_t cr_d_r [0:DOT_LEN-1];
  fx_t co_d_r [0:DOT_LEN-1];
  fx_t qa_r, qb_r, t1q_r, rrcc_r, qc_r;
  fx_t qa_d_r [0:QA_LEN-1];
  fx_t qb_d_r [0:QB_LEN-1];

  fx_t qbqb, qaqc, hn, h_r, hs;
  logic ok_r;
  logic ok_d_r [0:OK_LEN-1];
  fx_t hs_d_r [0:HS_LEN-1];

  fx_t num1_r, den1_r, t1, tcr, y_r;
  fx_t t1_d_r [0:T1_LEN-1];
  fx_t cc_y, co_y, cr_y;
  fx_t num2_r, den2_r, t2, qat2, s_r;
  logic side_r, crnz_r;
  logic side_d_r [0:SIDE_LEN-1];
  logic crnz_d_r [0:SIDE_LEN-1];
  fx_t t2_d_r [0:T2_LEN-1];

  fx_t t1_o, t2_o, hs_o, tsel;
  fx_mag_t s_mag;
  logic cap_ok, hit_nxt, fits;
  logic [CW-1:0] dist_nxt;
  logic [CW-1:0] dist_r;
  logic hit_r;

  assign en         = !vld_r[T_OUT] || out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = vld_r[T_OUT];
  assign out_tdata  = dist_r;
  assign out_tuser  = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_OUT-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= '0;
      base_r[1] <= '0;
      base_r[2] <= '0;
      top_r[0]  <= '0;
      top_r[1]  <= CW'(1) << FRAC_BITS;
      top_r[2]  <= '0;
      radius_r  <= (CW-1)'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_X: base_r[0] <= cfg_data;
        REG_BASE_Y: base_r[1] <= cfg_data;
        REG_BASE_Z: base_r[2] <= cfg_data;
        REG_TOP_X:  top_r[0]  <= cfg_data;
        REG_TOP_Y:  top_r[1]  <= cfg_data;
        REG_TOP_Z:  top_r[2]  <= cfg_data;
        REG_RADIUS: radius_r  <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // stage 0: axis and origin offsets
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ca_r[j]  <= sx(top_r[j]) - sx(base_r[j]);
        oc_r[j]  <= sx(in_tdata[j*CW +: CW]) - sx(base_r[j]);
        dir_r[j] <= sx(in_tdata[(3+j)*CW +: CW]);
      end
      rad0_r <= {{(WORD_W-CW+1){1'b0}}, radius_r};
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      m1_a[j]    = ca_r[j];  m1_b[j]    = ca_r[j];
      m1_a[3+j]  = ca_r[j];  m1_b[3+j]  = dir_r[j];
      m1_a[6+j]  = ca_r[j];  m1_b[6+j]  = oc_r[j];
      m1_a[9+j]  = oc_r[j];  m1_b[9+j]  = dir_r[j];
      m1_a[12+j] = oc_r[j];  m1_b[12+j] = oc_r[j];
    end
    m1_a[15] = rad0_r;
    m1_b[15] = rad0_r;
  end

  for (genvar g = 0; g < 16; g++) begin : g_m1
    rcc_fmul u_mul (.clk(clk), .en(en), .a(m1_a[g]), .b(m1_b[g]), .p(m1_p[g]));
  end

  // dot products: add left to right over two stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        a1_r[k]  <= fx_add(m1_p[3*k], m1_p[3*k+1]);
        a1z_r[k] <= m1_p[3*k+2];
        dot_r[k] <= fx_add(a1_r[k], a1z_r[k]);
      end
      rr_d_r[0] <= m1_p[15];
      for (int k = 1; k < RR_LEN; k++) rr_d_r[k] <= rr_d_r[k-1];
    end
  end

  rcc_fmul u_crcr (.clk(clk), .en(en), .a(dot_r[DOT_CR]), .b(dot_r[DOT_CR]), .p(crcr));
  rcc_fmul u_ccod (.clk(clk), .en(en), .a(dot_r[DOT_CC]), .b(dot_r[DOT_OD]), .p(ccod));
  rcc_fmul u_cocr (.clk(clk), .en(en), .a(dot_r[DOT_CO]), .b(dot_r[DOT_CR]), .p(cocr));
  rcc_fmul u_ccoo (.clk(clk), .en(en), .a(dot_r[DOT_CC]), .b(dot_r[DOT_OO]), .p(ccoo));
  rcc_fmul u_coco (.clk(clk), .en(en), .a(dot_r[DOT_CO]), .b(dot_r[DOT_CO]), .p(coco));
  rcc_fmul u_rrcc (.clk(clk), .en(en), .a(rr_d_r[RR_LEN-1]), .b(dot_r[DOT_CC]),
                   .p(rrcc));

  // quadratic coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      qa_r   <= fx_sub(cc_d_r[T_M2-T_DOT-1], crcr);
      qb_r   <= fx_sub(ccod, cocr);
      t1q_r  <= fx_sub(ccoo, coco);
      rrcc_r <= rrcc;
      qc_r   <= fx_sub(t1q_r, rrcc_r);
    end
  end

  rcc_fmul u_qbqb (.clk(clk), .en(en), .a(qb_d_r[0]), .b(qb_d_r[0]), .p(qbqb));
  rcc_fmul u_qaqc (.clk(clk), .en(en), .a(qa_d_r[0]), .b(qc_r), .p(qaqc));

  assign hn = fx_sub(qbqb, qaqc);

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= hn;
      ok_r <= !hn[WORD_W-1] && (qa_d_r[T_M3-T_Q1-1] != '0);
    end
  end

  rcc_sqrt u_sqrt (.clk(clk), .en(en), .x(h_r), .root(hs));

  // nearer root of the side surface; a zero divisor is replaced and masked
  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= fx_sub(-qb_d_r[T_SQ-T_Q1-1], hs);
      den1_r <= (qa_d_r[T_SQ-T_Q1-1] == '0) ? FX_ONE_LSB : qa_d_r[T_SQ-T_Q1-1];
    end
  end

  rcc_div u_div_side (.clk(clk), .en(en), .num(num1_r), .den(den1_r), .quo(t1));

  rcc_fmul u_tcr (.clk(clk), .en(en), .a(t1), .b(cr_d_r[T_D1-T_DOT-1]), .p(tcr));

  assign cc_y = cc_d_r[T_Y-T_DOT-1];
  assign co_y = co_d_r[T_Y-T_DOT-1];
  assign cr_y = cr_d_r[T_Y-T_DOT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      y_r    <= fx_add(co_d_r[T_M4-T_DOT-1], tcr);
      num2_r <= fx_sub(y_r[WORD_W-1] ? '0 : cc_y, co_y);
      den2_r <= (cr_y == '0) ? FX_ONE_LSB : cr_y;
      side_r <= (y_r > 0) && (y_r < cc_y);
      crnz_r <= cr_y != '0;
    end
  end

  rcc_div u_div_cap (.clk(clk), .en(en), .num(num2_r), .den(den2_r), .quo(t2));

  rcc_fmul u_qat2 (.clk(clk), .en(en), .a(qa_d_r[T_D2-T_Q1-1]), .b(t2), .p(qat2));

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= fx_add(qb_d_r[T_M5-T_Q1-1], qat2);
    end
  end

  // side-band delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      cc_d_r[0]   <= dot_r[DOT_CC];
      cr_d_r[0]   <= dot_r[DOT_CR];
      co_d_r[0]   <= dot_r[DOT_CO];
      qa_d_r[0]   <= qa_r;
      qb_d_r[0]   <= qb_r;
      ok_d_r[0]   <= ok_r;
      hs_d_r[0]   <= hs;
      t1_d_r[0]   <= t1;
      side_d_r[0] <= side_r;
      crnz_d_r[0] <= crnz_r;
      t2_d_r[0]   <= t2;
      for (int k = 1; k < DOT_LEN; k++) begin
        cc_d_r[k] <= cc_d_r[k-1];
        cr_d_r[k] <= cr_d_r[k-1];
        co_d_r[k] <= co_d_r[k-1];
      end
      for (int k = 1; k < QA_LEN; k++) qa_d_r[k] <= qa_d_r[k-1];
      for (int k = 1; k < QB_LEN; k++) qb_d_r[k] <= qb_d_r[k-1];
      for (int k = 1; k < OK_LEN; k++) ok_d_r[k] <= ok_d_r[k-1];
      for (int k = 1; k < HS_LEN; k++) hs_d_r[k] <= hs_d_r[k-1];
      for (int k = 1; k < T1_LEN; k++) t1_d_r[k] <= t1_d_r[k-1];
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_d_r[k] <= side_d_r[k-1];
        crnz_d_r[k] <= crnz_d_r[k-1];
      end
      for (int k = 1; k < T2_LEN; k++) t2_d_r[k] <= t2_d_r[k-1];
    end
  end

  // pick side or cap hit, then clamp to the field range
  assign t1_o  = t1_d_r[T1_LEN-1];
  assign t2_o  = t2_d_r[T2_LEN-1];
  assign hs_o  = hs_d_r[HS_LEN-1];
  assign s_mag = fx_abs(s_r);

  always_comb begin
    cap_ok  = ({1'b0, s_mag} < hs_o) && !t2_o[WORD_W-1] && (t2_o != '0);
    hit_nxt = ok_d_r[OK_LEN-1]
            && (side_d_r[SIDE_LEN-1] || (crnz_d_r[SIDE_LEN-1] && cap_ok));
    tsel    = side_d_r[SIDE_LEN-1] ? t1_o : t2_o;
    fits    = (&tsel[WORD_W-1:CW-1]) || !(|tsel[WORD_W-1:CW-1]);
    if (!hit_nxt) dist_nxt = '0;
    else if (fits) dist_nxt = tsel[CW-1:0];
    else if (tsel[WORD_W-1]) dist_nxt = {1'b1, {(CW-1){1'b0}}};
    else dist_nxt = {1'b0, {(CW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

`ifndef SYNTHESIS
  ap_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries a nonzero distance");

  ap_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted ray did not enter the pipe");

  ap_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipe moved while the result was stalled");
`endif

endmodule
